[rtl/core/prsd_pkg.sv]
// package for the palette run-length sprite decoder
// holds sizes, function, mode and register codes, and the phase and result kind types; no dependencies
`default_nettype none

package prsd_pkg;

    localparam int unsigned PAL_DEPTH = 256;
    localparam int unsigned PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int unsigned POS_BITS  = 24;
    // pixel position may reach 2^POS_BITS exactly, so one extra bit
    localparam int unsigned POS_W     = POS_BITS + 1;
    // compare width that holds both the frame size and a position plus a run
    localparam int unsigned CMP_W     = ((POS_BITS > 24) ? POS_BITS : 24) + 1;

    localparam logic [1:0] FN_PAL   = 2'd0;
    localparam logic [1:0] FN_FRAME = 2'd1;
    localparam logic [1:0] FN_DATA  = 2'd2;

    localparam logic [1:0] MODE_RGB  = 2'd0;
    localparam logic [1:0] MODE_RGBA = 2'd1;
    localparam logic [1:0] MODE_BGRA = 2'd2;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_KEY_R = 3'd1;
    localparam logic [2:0] CFG_KEY_G = 3'd2;
    localparam logic [2:0] CFG_KEY_B = 3'd3;
    localparam logic [2:0] CFG_THR   = 3'd4;
    localparam logic [2:0] CFG_FRAME = 3'd5;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_ALPHA = 2'd1,
        PH_INDEX = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_ERR  = 2'd1,
        K_KEY  = 2'd2,
        K_LIT  = 2'd3
    } t_kind;

endpackage

`default_nettype wire

[rtl/core/palette_rle_sprite_decoder.sv]
// palette run-length sprite decoder, top level
// parser registers, palette memory, blend pipeline; uses prsd_pkg
`default_nettype none

// One request per cycle is taken while the output side keeps up; a result
// passes the palette read, the multiply stage and the output register. Ready
// drops only while the output register holds a result that is not taken,
// and the whole pipeline then holds. The palette is a 256 x 24 single
// write, single read memory with registered read data; a palette write and
// a following index byte never meet at the same edge, so no forwarding is
// needed. Palette entries read before they are written return undefined
// colours. Configuration must only be written while no request is in flight.
module palette_rle_sprite_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_pal_index,
    input  wire logic [7:0]  i_pal_red,
    input  wire logic [7:0]  i_pal_green,
    input  wire logic [7:0]  i_pal_blue,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_status,
    output logic [23:0]      o_start_pos,
    output logic [7:0]       o_repeat_res,
    output logic [7:0]       o_chan0,
    output logic [7:0]       o_chan1,
    output logic [7:0]       o_chan2,
    output logic [7:0]       o_chan3
);

    localparam int unsigned PW = prsd_pkg::POS_W;
    localparam int unsigned CW = prsd_pkg::CMP_W;
    localparam int unsigned AW = prsd_pkg::PAL_AW;

    // configuration
    logic [1:0]  r_mode;
    logic [7:0]  r_key_r, r_key_g, r_key_b, r_thr;
    logic [23:0] r_frame;

    // parser state
    prsd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_left, n_left;
    logic [7:0]       r_alpha, n_alpha;
    logic [PW-1:0]    r_pos, n_pos;
    logic             r_ovf, n_ovf;

    // pipeline
    logic en, in_acc;
    prsd_pkg::t_kind s0_kind;
    logic [7:0]      s0_rep;
    logic            s0_oor;

    prsd_pkg::t_kind r_s1_kind;
    logic [23:0]     r_s1_pos;
    logic [7:0]      r_s1_rep, r_s1_alpha;
    logic            r_s1_oor;
    logic [23:0]     r_pal_q;

    prsd_pkg::t_kind r_s2_kind;
    logic [23:0]     r_s2_pos;
    logic [7:0]      r_s2_rep, r_s2_alpha;
    logic [7:0]      r_s2_r, r_s2_g, r_s2_b;
    logic [15:0]     r_s2_pr, r_s2_pg, r_s2_pb;
    logic [15:0]     r_s2_kr, r_s2_kg, r_s2_kb;

    logic        r_out_valid;
    logic        r_out_status;
    logic [23:0] r_out_pos;
    logic [7:0]  r_out_rep, r_out_c0, r_out_c1, r_out_c2, r_out_c3;

    logic [23:0] r_pal_mem [prsd_pkg::PAL_DEPTH];

    logic [CW-1:0] pos_w, lim_w, cap_w, run_end;
    logic          at_limit, run_over;
    logic          pal_we;

    assign en         = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && en;
    assign o_in_ready = en;

    assign cap_w    = CW'(1) << prsd_pkg::POS_BITS;
    assign lim_w    = (CW'(r_frame) < cap_w) ? CW'(r_frame) : cap_w;
    assign pos_w    = CW'(r_pos);
    assign run_end  = pos_w + CW'(r_left);
    assign at_limit = pos_w >= lim_w;
    assign run_over = run_end > lim_w;

    assign pal_we = in_acc && (i_func == prsd_pkg::FN_PAL)
                    && ({1'b0, i_pal_index} < 9'(prsd_pkg::PAL_DEPTH));

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_alpha = r_alpha;
        n_pos   = r_pos;
        n_ovf   = r_ovf;
        s0_kind = prsd_pkg::K_NONE;
        s0_rep  = 8'd0;
        s0_oor  = !({1'b0, i_data_byte} < 9'(prsd_pkg::PAL_DEPTH));
        case (i_func)
            prsd_pkg::FN_FRAME: begin
                n_phase = prsd_pkg::PH_COUNT;
                n_left  = 8'd0;
                n_alpha = 8'd0;
                n_pos   = '0;
                n_ovf   = 1'b0;
            end
            prsd_pkg::FN_DATA: begin
                if (!r_ovf) begin
                    case (r_phase)
                        prsd_pkg::PH_ALPHA: begin
                            if (i_data_byte == 8'd0) begin
                                n_phase = prsd_pkg::PH_COUNT;
                                if (r_left != 8'd0) begin
                                    if (run_over) begin
                                        n_ovf   = 1'b1;
                                        s0_kind = prsd_pkg::K_ERR;
                                    end else begin
                                        s0_kind = prsd_pkg::K_KEY;
                                        s0_rep  = r_left;
                                        n_pos   = PW'(run_end);
                                        n_left  = 8'd0;
                                    end
                                end
                            end else begin
                                n_alpha = i_data_byte;
                                n_phase = (r_left == 8'd0) ? prsd_pkg::PH_COUNT
                                                           : prsd_pkg::PH_INDEX;
                            end
                        end
                        prsd_pkg::PH_INDEX: begin
                            if (at_limit) begin
                                n_ovf   = 1'b1;
                                s0_kind = prsd_pkg::K_ERR;
                            end else begin
                                s0_kind = prsd_pkg::K_LIT;
                                s0_rep  = 8'd1;
                                n_pos   = r_pos + PW'(1);
                                n_left  = r_left - 8'd1;
                                if (r_left == 8'd1) begin
                                    n_phase = prsd_pkg::PH_COUNT;
                                end
                            end
                        end
                        default: begin
                            // count byte; the unused phase code lands here too
                            n_left  = i_data_byte;
                            n_phase = prsd_pkg::PH_ALPHA;
                            if (at_limit) begin
                                n_ovf   = 1'b1;
                                s0_kind = prsd_pkg::K_ERR;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= prsd_pkg::MODE_RGB;
            r_key_r <= 8'd0;
            r_key_g <= 8'd0;
            r_key_b <= 8'd0;
            r_thr   <= 8'd0;
            r_frame <= 24'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                prsd_pkg::CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                prsd_pkg::CFG_KEY_R: r_key_r <= i_cfg_data[7:0];
                prsd_pkg::CFG_KEY_G: r_key_g <= i_cfg_data[7:0];
                prsd_pkg::CFG_KEY_B: r_key_b <= i_cfg_data[7:0];
                prsd_pkg::CFG_THR:   r_thr   <= i_cfg_data[7:0];
                prsd_pkg::CFG_FRAME: r_frame <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= prsd_pkg::PH_COUNT;
            r_left  <= 8'd0;
            r_alpha <= 8'd0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_alpha <= n_alpha;
            r_pos   <= n_pos;
            r_ovf   <= n_ovf;
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal_mem[i_pal_index[AW-1:0]] <= {i_pal_red, i_pal_green, i_pal_blue};
        end
        if (en) begin
            r_pal_q <= r_pal_mem[i_data_byte[AW-1:0]];
        end
    end

    // stage 1: request decoded, palette read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_kind <= prsd_pkg::K_NONE;
        end else if (en) begin
            r_s1_kind <= in_acc ? s0_kind : prsd_pkg::K_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pos   <= pos_w[23:0];
            r_s1_rep   <= s0_rep;
            r_s1_alpha <= r_alpha;
            r_s1_oor   <= s0_oor;
        end
    end

    // stage 2: blend products
    logic [7:0] s1_r, s1_g, s1_b, s1_inv;

    always_comb begin
        s1_r   = r_s1_oor ? 8'd0 : r_pal_q[23:16];
        s1_g   = r_s1_oor ? 8'd0 : r_pal_q[15:8];
        s1_b   = r_s1_oor ? 8'd0 : r_pal_q[7:0];
        s1_inv = 8'hFF - r_s1_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_kind <= prsd_pkg::K_NONE;
        end else if (en) begin
            r_s2_kind <= r_s1_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_pos   <= r_s1_pos;
            r_s2_rep   <= r_s1_rep;
            r_s2_alpha <= r_s1_alpha;
            r_s2_r     <= s1_r;
            r_s2_g     <= s1_g;
            r_s2_b     <= s1_b;
            r_s2_pr    <= s1_r * r_s1_alpha;
            r_s2_pg    <= s1_g * r_s1_alpha;
            r_s2_pb    <= s1_b * r_s1_alpha;
            r_s2_kr    <= r_key_r * s1_inv;
            r_s2_kg    <= r_key_g * s1_inv;
            r_s2_kb    <= r_key_b * s1_inv;
        end
    end

    // floor(x / 255) of x = a + b, for x below 65280 so that the quotient fits 8 bits
    function automatic logic [7:0] div255(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] x;
        logic [16:0] t;
        x = {1'b0, a} + {1'b0, b};
        t = x + 17'd1 + {8'd0, x[16:8]};
        return t[15:8];
    endfunction

    // stage 3: colour selection into the output register
    logic [7:0] c_r, c_g, c_b, c_a;
    logic       c_status;
    logic       alpha_mode;

    always_comb begin
        alpha_mode = (r_mode == prsd_pkg::MODE_RGBA) || (r_mode == prsd_pkg::MODE_BGRA);
        c_status   = 1'b0;
        c_r        = r_key_r;
        c_g        = r_key_g;
        c_b        = r_key_b;
        c_a        = 8'd0;
        case (r_s2_kind)
            prsd_pkg::K_ERR: begin
                c_status = 1'b1;
                c_r      = 8'd0;
                c_g      = 8'd0;
                c_b      = 8'd0;
            end
            prsd_pkg::K_LIT: begin
                if (alpha_mode) begin
                    c_r = r_s2_r;
                    c_g = r_s2_g;
                    c_b = r_s2_b;
                    c_a = r_s2_alpha;
                end else if (!(r_s2_alpha < r_thr)) begin
                    c_r = div255(r_s2_pr, r_s2_kr);
                    c_g = div255(r_s2_pg, r_s2_kg);
                    c_b = div255(r_s2_pb, r_s2_kb);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= (r_s2_kind != prsd_pkg::K_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_status <= c_status;
            r_out_pos    <= r_s2_pos;
            r_out_rep    <= c_status ? 8'd0 : r_s2_rep;
            r_out_c1     <= c_g;
            r_out_c3     <= alpha_mode ? c_a : 8'd0;
            if (r_mode == prsd_pkg::MODE_BGRA) begin
                r_out_c0 <= c_b;
                r_out_c2 <= c_r;
            end else begin
                r_out_c0 <= c_r;
                r_out_c2 <= c_b;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_start_pos  = r_out_pos;
    assign o_repeat_res = r_out_rep;
    assign o_chan0      = r_out_c0;
    assign o_chan1      = r_out_c1;
    assign o_chan2      = r_out_c2;
    assign o_chan3      = r_out_c3;

endmodule

`default_nettype wire

[verif/prsd_run_checker.sv]
// checker for the palette run-length sprite decoder: watches the register port
// and the request and result channels, predicts each pixel run and compares it
// depends on prsd_pkg
`timescale 1ns / 1ps

module prsd_run_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_pal_index,
    input  wire logic [7:0]  i_pal_red,
    input  wire logic [7:0]  i_pal_green,
    input  wire logic [7:0]  i_pal_blue,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_status,
    input  wire logic [23:0] i_start_pos,
    input  wire logic [7:0]  i_repeat_res,
    input  wire logic [7:0]  i_chan0,
    input  wire logic [7:0]  i_chan1,
    input  wire logic [7:0]  i_chan2,
    input  wire logic [7:0]  i_chan3,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic        status;
        logic [23:0] start_pos;
        logic [7:0]  repeat_res;
        logic [7:0]  chan0;
        logic [7:0]  chan1;
        logic [7:0]  chan2;
        logic [7:0]  chan3;
    } t_run;

    // predicted decoder state
    logic [23:0]               pal_mem [prsd_pkg::PAL_DEPTH];
    prsd_pkg::t_phase          phase = prsd_pkg::PH_COUNT;
    logic [7:0]                run_left = '0;
    logic [7:0]                run_alpha = '0;
    logic [prsd_pkg::POS_W-1:0] pix_pos = '0;
    logic                      overflowed = 1'b0;

    // shadow of the configuration registers
    logic [1:0]  mode = prsd_pkg::MODE_RGB;
    logic [7:0]  key_r = '0;
    logic [7:0]  key_g = '0;
    logic [7:0]  key_b = '0;
    logic [7:0]  thr = '0;
    logic [23:0] frame_px = '0;

    t_run runs_due [$];
    t_run fresh;
    t_run got;
    t_run want;
    bit   made;
    int   fails = 0;

    function automatic t_run make_run(input logic st, input logic [23:0] pos,
                                      input logic [7:0] rep, r, g, b, a);
        t_run res;
        res.status     = st;
        res.start_pos  = pos;
        res.repeat_res = rep;
        res.chan0      = (mode == prsd_pkg::MODE_BGRA) ? b : r;
        res.chan1      = g;
        res.chan2      = (mode == prsd_pkg::MODE_BGRA) ? r : b;
        res.chan3      = (mode == prsd_pkg::MODE_RGBA || mode == prsd_pkg::MODE_BGRA)
                         ? a : 8'd0;
        return res;
    endfunction

    function automatic logic [7:0] blend_chan(input logic [7:0] p, k, a);
        int unsigned mix;
        mix = (32'(p) * 32'(a) + 32'(k) * (32'd255 - 32'(a))) / 32'd255;
        return mix[7:0];
    endfunction

    task automatic step_parser(input logic [1:0] fn, input logic [7:0] pidx, pr, pg, pb, db,
                               output bit produced, output t_run res);
        longint unsigned lim;
        logic [23:0]     col;
        produced = 1'b0;
        res = '0;
        // positions never run past 2^POS_BITS even with a larger frame
        lim = (64'(frame_px) < (64'd1 << prsd_pkg::POS_BITS)) ? 64'(frame_px)
                                                              : (64'd1 << prsd_pkg::POS_BITS);
        case (fn)
            prsd_pkg::FN_PAL: begin
                if (pidx < prsd_pkg::PAL_DEPTH) pal_mem[pidx] = {pr, pg, pb};
            end
            prsd_pkg::FN_FRAME: begin
                phase      = prsd_pkg::PH_COUNT;
                run_left   = '0;
                run_alpha  = '0;
                pix_pos    = '0;
                overflowed = 1'b0;
            end
            prsd_pkg::FN_DATA: begin
                if (!overflowed) begin
                    case (phase)
                        prsd_pkg::PH_ALPHA: begin
                            if (db == 8'd0) begin
                                phase = prsd_pkg::PH_COUNT;
                                if (run_left != 8'd0) begin
                                    produced = 1'b1;
                                    if (64'(pix_pos) + 64'(run_left) > lim) begin
                                        overflowed = 1'b1;
                                        res = make_run(1'b1, pix_pos[23:0], '0, '0, '0, '0, '0);
                                    end else begin
                                        res = make_run(1'b0, pix_pos[23:0], run_left,
                                                       key_r, key_g, key_b, 8'd0);
                                        pix_pos  = pix_pos + run_left;
                                        run_left = '0;
                                    end
                                end
                            end else begin
                                run_alpha = db;
                                phase = (run_left == 8'd0) ? prsd_pkg::PH_COUNT
                                                           : prsd_pkg::PH_INDEX;
                            end
                        end
                        prsd_pkg::PH_INDEX: begin
                            col = (db < prsd_pkg::PAL_DEPTH) ? pal_mem[db] : '0;
                            produced = 1'b1;
                            if (64'(pix_pos) >= lim) begin
                                overflowed = 1'b1;
                                res = make_run(1'b1, pix_pos[23:0], '0, '0, '0, '0, '0);
                            end else begin
                                if (mode == prsd_pkg::MODE_RGBA ||
                                    mode == prsd_pkg::MODE_BGRA) begin
                                    res = make_run(1'b0, pix_pos[23:0], 8'd1, col[23:16],
                                                   col[15:8], col[7:0], run_alpha);
                                end else if (run_alpha < thr) begin
                                    res = make_run(1'b0, pix_pos[23:0], 8'd1,
                                                   key_r, key_g, key_b, 8'd0);
                                end else begin
                                    res = make_run(1'b0, pix_pos[23:0], 8'd1,
                                                   blend_chan(col[23:16], key_r, run_alpha),
                                                   blend_chan(col[15:8], key_g, run_alpha),
                                                   blend_chan(col[7:0], key_b, run_alpha),
                                                   8'd0);
                                end
                                pix_pos  = pix_pos + 1'b1;
                                run_left = run_left - 8'd1;
                                if (run_left == 8'd0) phase = prsd_pkg::PH_COUNT;
                            end
                        end
                        default: begin
                            run_left = db;
                            phase    = prsd_pkg::PH_ALPHA;
                            if (64'(pix_pos) >= lim) begin
                                produced   = 1'b1;
                                overflowed = 1'b1;
                                res = make_run(1'b1, pix_pos[23:0], '0, '0, '0, '0, '0);
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string fname, input logic [23:0] want_v, got_v);
        if (got_v !== want_v) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v,
                     got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = prsd_pkg::PH_COUNT;
            run_left   = '0;
            run_alpha  = '0;
            pix_pos    = '0;
            overflowed = 1'b0;
            mode       = prsd_pkg::MODE_RGB;
            key_r      = '0;
            key_g      = '0;
            key_b      = '0;
            thr        = '0;
            frame_px   = '0;
            runs_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    prsd_pkg::CFG_MODE:  mode     = i_cfg_data[1:0];
                    prsd_pkg::CFG_KEY_R: key_r    = i_cfg_data[7:0];
                    prsd_pkg::CFG_KEY_G: key_g    = i_cfg_data[7:0];
                    prsd_pkg::CFG_KEY_B: key_b    = i_cfg_data[7:0];
                    prsd_pkg::CFG_THR:   thr      = i_cfg_data[7:0];
                    prsd_pkg::CFG_FRAME: frame_px = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                step_parser(i_func, i_pal_index, i_pal_red, i_pal_green, i_pal_blue,
                            i_data_byte, made, fresh);
                if (made) runs_due.push_back(fresh);
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_start_pos, i_repeat_res, i_chan0, i_chan1, i_chan2, i_chan3};
                if (runs_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual %0h", $time,
                             got);
                end else begin
                    want = runs_due.pop_front();
                    check_field("status", 24'(want.status), 24'(got.status));
                    check_field("start_pos", want.start_pos, got.start_pos);
                    check_field("repeat_res", 24'(want.repeat_res), 24'(got.repeat_res));
                    check_field("chan0", 24'(want.chan0), 24'(got.chan0));
                    check_field("chan1", 24'(want.chan1), 24'(got.chan1));
                    check_field("chan2", 24'(want.chan2), 24'(got.chan2));
                    check_field("chan3", 24'(want.chan3), 24'(got.chan3));
                end
            end
        end
        o_pending    <= runs_due.size();
        o_fail_count <= fails;
    end

endmodule

[verif/tb_top.sv]
// testbench top for the palette run-length sprite decoder: drives palette,
// frame and data requests and the registers, and gives the verdict
// depends on prsd_pkg, palette_rle_sprite_decoder and prsd_run_checker
`timescale 1ns / 1ps

module tb_top;

    // colour mode code the block leaves unused, treated as rgb
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // function code the block ignores
    localparam logic [1:0] FN_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = prsd_pkg::CFG_MODE;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = prsd_pkg::FN_PAL;
    logic [7:0]  pal_index = '0;
    logic [7:0]  pal_red = '0;
    logic [7:0]  pal_green = '0;
    logic [7:0]  pal_blue = '0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        status;
    logic [23:0] start_pos;
    logic [7:0]  repeat_res;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic [7:0]  chan3;
    int          fail_count;
    int          pending;

    bit          steady = 1'b0;
    bit          pal_written [prsd_pkg::PAL_DEPTH];
    logic [7:0]  written_idx [$];

    palette_rle_sprite_decoder dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (func),
        .i_pal_index  (pal_index),
        .i_pal_red    (pal_red),
        .i_pal_green  (pal_green),
        .i_pal_blue   (pal_blue),
        .i_data_byte  (data_byte),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_start_pos  (start_pos),
        .o_repeat_res (repeat_res),
        .o_chan0      (chan0),
        .o_chan1      (chan1),
        .o_chan2      (chan2),
        .o_chan3      (chan3)
    );

    prsd_run_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_func       (func),
        .i_pal_index  (pal_index),
        .i_pal_red    (pal_red),
        .i_pal_green  (pal_green),
        .i_pal_blue   (pal_blue),
        .i_data_byte  (data_byte),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_status     (status),
        .i_start_pos  (start_pos),
        .i_repeat_res (repeat_res),
        .i_chan0      (chan0),
        .i_chan1      (chan1),
        .i_chan2      (chan2),
        .i_chan3      (chan3),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 6);
    end

    task automatic send_request(input logic [1:0] fn, input logic [7:0] pidx, pr, pg, pb, db);
        if (!steady && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= fn;
        pal_index <= pidx;
        pal_red   <= pr;
        pal_green <= pg;
        pal_blue  <= pb;
        data_byte <= db;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_palette(input logic [7:0] idx, r, g, b);
        send_request(prsd_pkg::FN_PAL, idx, r, g, b, 8'($urandom));
        if (!pal_written[idx]) begin
            pal_written[idx] = 1'b1;
            written_idx.push_back(idx);
        end
    endtask

    task automatic send_byte(input logic [7:0] db);
        send_request(prsd_pkg::FN_DATA, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), db);
    endtask

    task automatic frame_start();
        send_request(prsd_pkg::FN_FRAME, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
    endtask

    task automatic send_junk();
        send_request(FN_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
    endtask

    // only entries already written may be used as index bytes
    function automatic logic [7:0] pick_index();
        return written_idx[$urandom_range(written_idx.size() - 1)];
    endfunction

    // no request in flight and every result taken, then the pipeline drains
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [7:0] kr, kg, kb, thr,
                              input logic [23:0] frame);
        logic [2:0]  regs [6];
        logic [23:0] vals [6];
        regs = '{prsd_pkg::CFG_MODE, prsd_pkg::CFG_KEY_R, prsd_pkg::CFG_KEY_G,
                 prsd_pkg::CFG_KEY_B, prsd_pkg::CFG_THR, prsd_pkg::CFG_FRAME};
        // upper data bits are don't-care for the narrow registers
        vals = '{{22'($urandom), mode}, {16'($urandom), kr}, {16'($urandom), kg},
                 {16'($urandom), kb}, {16'($urandom), thr}, frame};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input int n_items);
        int         sent;
        int         dice;
        int         k;
        logic [7:0] count;
        logic [7:0] alpha;
        sent = 0;
        while (sent < n_items) begin
            dice = $urandom_range(99);
            if (dice < 7) begin
                frame_start();
                sent++;
            end else if (dice < 15) begin
                write_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                sent++;
            end else if (dice < 19) begin
                send_junk();
            end else if (dice < 23) begin
                // broken run: stray bytes, then resync on a frame start
                send_byte(8'($urandom));
                k = $urandom_range(0, 2);
                repeat (k) send_byte(pick_index());
                frame_start();
                sent += k + 2;
            end else begin
                dice = $urandom_range(99);
                if (dice < 8) count = 8'd0;
                else if (dice < 70) count = 8'($urandom_range(1, 6));
                else if (dice < 97) count = 8'($urandom_range(7, 30));
                else count = 8'($urandom);
                dice = $urandom_range(99);
                if (dice < 35) alpha = 8'd0;
                else if (dice < 42) alpha = 8'd1;
                else if (dice < 49) alpha = 8'hFF;
                else alpha = 8'($urandom_range(1, 255));
                // long runs mostly as key runs to keep the item count sane
                if (count > 8'd30 && $urandom_range(99) < 80) alpha = 8'd0;
                send_byte(count);
                send_byte(alpha);
                sent += 2;
                if (alpha != 8'd0) begin
                    repeat (count) send_byte(pick_index());
                    sent += count;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(prsd_pkg::MODE_RGB, 8'h12, 8'h34, 8'h56, 8'h80, 24'd20);
        write_palette(8'd0, 8'h00, 8'h00, 8'h00);
        write_palette(8'd255, 8'hFF, 8'hFF, 8'hFF);
        write_palette(8'd1, 8'hA5, 8'h5A, 8'hC3);
        // data ahead of any frame start parses from the reset state
        send_byte(8'd2);
        send_byte(8'd0);
        frame_start();
        send_byte(8'd3);
        send_byte(8'hFF);
        send_byte(8'd0);
        send_byte(8'd255);
        send_byte(8'd1);
        // zero count gives nothing, parser back to count
        send_byte(8'd0);
        send_byte(8'd7);
        send_junk();
        send_byte(8'd16);
        send_byte(8'd0);
        // alpha equal to threshold blends; second pixel lands on the frame end
        send_byte(8'd2);
        send_byte(8'h80);
        send_byte(8'd1);
        send_byte(8'd0);
        frame_start();
        // key run that ends exactly on the frame size, then a count at the limit
        send_byte(8'd20);
        send_byte(8'd0);
        send_byte(8'd1);
        frame_start();
        send_byte(8'd255);
        send_byte(8'd0);
        wait_drained();

        set_config(prsd_pkg::MODE_RGB, 8'h00, 8'h00, 8'h00, 8'h00, 24'd60);
        random_traffic(200);
        wait_drained();
        set_config(prsd_pkg::MODE_RGB, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'd100);
        random_traffic(200);
        wait_drained();
        set_config(prsd_pkg::MODE_RGBA, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 24'd0);
        random_traffic(120);
        wait_drained();
        steady = 1'b1;
        set_config(prsd_pkg::MODE_BGRA, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 24'hFFFFFF);
        random_traffic(200);
        wait_drained();
        steady = 1'b0;
        set_config(MODE_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   24'($urandom_range(1, 300)));
        random_traffic(200);
        wait_drained();
        set_config(prsd_pkg::MODE_RGB, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 24'd50);
        random_traffic(280);
        wait_drained();

        if (fail_count == 0) begin
            $display("[palette_rle_sprite_decoder] OK");
        end else begin
            $display("[palette_rle_sprite_decoder] ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[palette_rle_sprite_decoder] ERROR");
        $finish;
    end

endmodule
